// ----- src/audio_module_command_framer_top_macros.svh -----
// Assertion macros shared by the framer modules.
// No dependencies; included by the files that carry assertions.
`ifndef AUDIO_MODULE_COMMAND_FRAMER_TOP_MACROS_SVH
`define AUDIO_MODULE_COMMAND_FRAMER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ACF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ACF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer assertion failed");
`else
`define ACF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ACF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/acf_pkg.sv -----
// Types, byte codes and sizes for the audio module command framer.
// No dependencies; imported by every framer module.
package acf_pkg;

    localparam int ACF_MAX_BYTES   = 11;
    localparam int ACF_LEN_W       = 4;
    localparam int ACF_QUEUE_DEPTH = 2;

    // Command opcodes.
    localparam logic [1:0] OP_VOLUME = 2'd0;
    localparam logic [1:0] OP_PLAY   = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;

    // Stop group kinds.
    localparam logic [1:0] STOP_HALT   = 2'd0;
    localparam logic [1:0] STOP_PAUSE  = 2'd1;
    localparam logic [1:0] STOP_RESUME = 2'd2;
    localparam logic [1:0] STOP_NONE   = 2'd3;

    // Link modes.
    localparam logic LINK_ONE_WIRE = 1'b0;
    localparam logic LINK_SERIAL   = 1'b1;

    // Byte codes on the module link.
    localparam logic [7:0] MARK_START   = 8'hAA;
    localparam logic [7:0] CMD_VOLUME   = 8'h13;
    localparam logic [7:0] CMD_PLAY     = 8'h07;
    localparam logic [7:0] CMD_LOOP     = 8'h18;
    localparam logic [7:0] OW_NUM_LEAD  = 8'h0A;
    localparam logic [7:0] OW_TRACK_END = 8'h0B;
    localparam logic [7:0] OW_VOL_END   = 8'h0C;
    localparam logic [7:0] OW_LOOP_END  = 8'h0E;
    localparam logic [7:0] OW_PLAY      = 8'h11;
    localparam logic [7:0] OW_PAUSE     = 8'h12;
    localparam logic [7:0] OW_STOP      = 8'h13;
    localparam logic [7:0] SER_STOP     = 8'h04;
    localparam logic [7:0] SER_PAUSE    = 8'h03;
    localparam logic [7:0] SER_RESUME   = 8'h02;
    localparam logic [7:0] LOOP_CODE_ON  = 8'h01;
    localparam logic [7:0] LOOP_CODE_OFF = 8'h02;
    localparam logic [7:0] LEN_ZERO     = 8'h00;
    localparam logic [7:0] LEN_ONE      = 8'h01;
    localparam logic [7:0] LEN_TWO      = 8'h02;

    // Constant parts of the serial checksums (start, command and length bytes).
    localparam logic [7:0] SUM_VOLUME = MARK_START + CMD_VOLUME + LEN_ONE;
    localparam logic [7:0] SUM_LOOP   = MARK_START + CMD_LOOP + LEN_ONE;
    localparam logic [7:0] SUM_PLAY   = MARK_START + CMD_PLAY + LEN_TWO;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] value;
        logic       loop_select;
        logic [1:0] stop_kind;
    } acf_cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } acf_byte_t;

    // One classified command: its bytes in send order and how many there are.
    typedef struct packed {
        logic [ACF_MAX_BYTES-1:0][7:0] bytes;
        logic [ACF_LEN_W-1:0]          len;
    } acf_desc_t;

endpackage

// ----- src/acf_front.sv -----
// Front end of the framer: takes commands and turns each into a byte list.
// Depends on acf_pkg.
module acf_front
    import acf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      link_mode,
    input  logic      in_valid,
    output logic      in_ready,
    input  acf_cmd_t  in_data,
    output logic      push_valid,
    input  logic      push_ready,
    output acf_desc_t push_desc
);

    acf_cmd_t   hold_reg;
    logic       hold_valid_reg;
    logic       hold_valid_next;
    acf_desc_t  desc;
    logic       drain;
    logic [15:0] prod10;
    logic [15:0] prod100;
    logic [4:0]  q10;
    logic [1:0]  q100;
    logic [4:0]  tens;
    logic [7:0]  units;
    logic [7:0]  loop_code;
    logic [7:0]  stop_code;

    // Decimal digits by reciprocal multiplication; exact for all 8-bit values.
    assign prod10  = {8'd0, hold_reg.value} * 16'd205;
    assign prod100 = {8'd0, hold_reg.value} * 16'd41;
    assign q10     = prod10[15:11];
    assign q100    = prod100[13:12];
    assign tens    = q10 - 5'({3'd0, q100} * 5'd10);
    assign units   = hold_reg.value - 8'({3'd0, q10} * 8'd10);

    assign loop_code = hold_reg.loop_select ? LOOP_CODE_ON : LOOP_CODE_OFF;

    always_comb
    begin
        stop_code = LEN_ZERO;
        unique case (hold_reg.stop_kind)
            STOP_HALT:   stop_code = (link_mode == LINK_SERIAL) ? SER_STOP : OW_STOP;
            STOP_PAUSE:  stop_code = (link_mode == LINK_SERIAL) ? SER_PAUSE : OW_PAUSE;
            STOP_RESUME: stop_code = (link_mode == LINK_SERIAL) ? SER_RESUME : OW_PLAY;
            default:     stop_code = LEN_ZERO;
        endcase
    end

    always_comb
    begin
        desc = '0;
        unique case (hold_reg.opcode)
            OP_VOLUME:
            begin
                if (link_mode == LINK_ONE_WIRE)
                begin
                    desc.bytes[0] = OW_NUM_LEAD;
                    desc.bytes[1] = {3'd0, q10};
                    desc.bytes[2] = units;
                    desc.bytes[3] = OW_VOL_END;
                    desc.len      = 4'd4;
                end
                else
                begin
                    desc.bytes[0] = MARK_START;
                    desc.bytes[1] = CMD_VOLUME;
                    desc.bytes[2] = LEN_ONE;
                    desc.bytes[3] = hold_reg.value;
                    desc.bytes[4] = SUM_VOLUME + hold_reg.value;
                    desc.len      = 4'd5;
                end
            end
            OP_PLAY:
            begin
                if (link_mode == LINK_ONE_WIRE)
                begin
                    desc.bytes[0] = OW_NUM_LEAD;
                    desc.bytes[1] = {6'd0, q100};
                    desc.bytes[2] = {3'd0, tens};
                    desc.bytes[3] = units;
                    desc.bytes[4] = OW_TRACK_END;
                    desc.bytes[5] = OW_NUM_LEAD;
                    desc.bytes[6] = loop_code;
                    desc.bytes[7] = OW_LOOP_END;
                    desc.bytes[8] = OW_PLAY;
                    desc.len      = 4'd9;
                end
                else
                begin
                    desc.bytes[0]  = MARK_START;
                    desc.bytes[1]  = CMD_LOOP;
                    desc.bytes[2]  = LEN_ONE;
                    desc.bytes[3]  = loop_code;
                    desc.bytes[4]  = SUM_LOOP + loop_code;
                    desc.bytes[5]  = MARK_START;
                    desc.bytes[6]  = CMD_PLAY;
                    desc.bytes[7]  = LEN_TWO;
                    desc.bytes[8]  = LEN_ZERO;
                    desc.bytes[9]  = hold_reg.value;
                    desc.bytes[10] = SUM_PLAY + hold_reg.value;
                    desc.len       = 4'd11;
                end
            end
            OP_STOP:
            begin
                if (hold_reg.stop_kind != STOP_NONE)
                begin
                    if (link_mode == LINK_ONE_WIRE)
                    begin
                        desc.bytes[0] = stop_code;
                        desc.len      = 4'd1;
                    end
                    else
                    begin
                        desc.bytes[0] = MARK_START;
                        desc.bytes[1] = stop_code;
                        desc.bytes[2] = LEN_ZERO;
                        desc.bytes[3] = MARK_START + stop_code;
                        desc.len      = 4'd4;
                    end
                end
            end
            default:
            begin
                desc = '0;
            end
        endcase
    end

    assign push_desc = desc;

    // Commands that produce no bytes are dropped here without a queue entry.
    assign push_valid = hold_valid_reg && (desc.len != '0);
    assign drain      = hold_valid_reg && ((desc.len == '0) || push_ready);
    assign in_ready   = !hold_valid_reg || drain;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_valid && in_ready)
            hold_valid_next = 1'b1;
        else if (drain)
            hold_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            hold_reg <= in_data;
    end

endmodule

// ----- src/acf_queue.sv -----
// Short register queue of classified commands between front and back end.
// Depends on acf_pkg and the assertion macro header.
`include "audio_module_command_framer_top_macros.svh"
module acf_queue
    import acf_pkg::*;
#(
    parameter int DEPTH = ACF_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  acf_desc_t push_desc,
    output logic      pop_valid,
    input  logic      pop,
    output acf_desc_t pop_desc
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    acf_desc_t       mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_desc   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

    `ACF_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH))
    `ACF_ASSERT_NEXT(a_push_only_grows, clk, rst_n, do_push && !do_pop, count_reg != '0)

endmodule

// ----- src/acf_back.sv -----
// Back end of the framer: sends the bytes of each queued command, one byte per cycle while the output is not stalled.
// Depends on acf_pkg and the assertion macro header.
`include "audio_module_command_framer_top_macros.svh"
module acf_back
    import acf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_pop,
    input  acf_desc_t q_desc,
    output logic      out_valid,
    input  logic      out_ready,
    output acf_byte_t out_data
);

    acf_desc_t            cur_reg;
    acf_desc_t            cur_next;
    logic [ACF_LEN_W-1:0] cnt_reg;
    logic [ACF_LEN_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    acf_byte_t            out_reg;
    acf_byte_t            out_next;
    logic                 advance;
    logic                 last_now;

    assign advance  = !out_valid_reg || out_ready;
    assign last_now = (cnt_reg == cur_reg.len - 1'b1);

    // A new command is taken as the final byte of the current one moves out,
    // so commands follow each other without a gap.
    assign q_pop = q_valid && (!busy_reg || (advance && last_now));

    always_comb
    begin
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next    = busy_reg;
            out_next.out_byte = cur_reg.bytes[cnt_reg];
            out_next.last     = last_now;
            if (busy_reg)
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_now)
                    busy_next = 1'b0;
            end
        end
        if (q_pop)
        begin
            cur_next  = q_desc;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `ACF_ASSERT_IMPL(a_cnt_in_range, clk, rst_n, busy_reg, cnt_reg < cur_reg.len)
    `ACF_ASSERT_IMPL(a_load_nonempty, clk, rst_n, q_pop, q_desc.len != '0)

endmodule

// ----- src/audio_module_command_framer_top.sv -----
// Top level of the audio module command framer: APB register and channels.
// Depends on acf_pkg, acf_front, acf_queue and acf_back.
//
// Usage:
// Commands enter as one transfer each on the in channel (valid/ready); the
// resulting link bytes leave on the out channel, one byte per transfer, with
// last set on the final byte of each command. A command yields 1 to 11 bytes;
// a stop command of the no-action kind and the unused opcode yield none.
// When the block is empty, the first byte of a command passes the hold register,
// a queue entry, the back end's command register and the output register. The
// back end sends one byte per cycle while the receiver does not stall and runs
// from command to command without a gap; the front end classifies one command
// per cycle, while the queue has room, into a queue of QUEUE_DEPTH entries.
// When the receiver stalls, the output register holds its byte, the back end
// stops, the queue fills and then in_ready drops; nothing is lost.
// Reset empties the front register, the queue and the output register and
// sets link_mode to one-wire. The user writes link_mode (register 0, address 0)
// over APB only while no command is in flight; the block does not enforce it.
module audio_module_command_framer_top
    import acf_pkg::*;
#(
    parameter int QUEUE_DEPTH = ACF_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  acf_cmd_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output acf_byte_t   out_data
);

    logic      link_mode_reg;
    logic      link_mode_next;
    logic      push_valid;
    logic      push_ready;
    acf_desc_t push_desc;
    logic      q_valid;
    logic      q_pop;
    acf_desc_t q_desc;

    // The single register sits in the word at address 0; bit 2 selects the word.
    assign pready = 1'b1;

    always_comb
    begin
        link_mode_next = link_mode_reg;
        if (psel && penable && pwrite && pready && !paddr[2])
            link_mode_next = pwdata[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            link_mode_reg <= LINK_ONE_WIRE;
        else
            link_mode_reg <= link_mode_next;
    end

    assign prdata = paddr[2] ? 32'd0 : {31'd0, link_mode_reg};

    acf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .link_mode  (link_mode_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    acf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_desc   (q_desc)
    );

    acf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_desc    (q_desc),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
